// File: hdl/rv32eb_pkg.sv
// shared types and codes for the rv32 execute and branch unit
`default_nettype none
package rv32eb_pkg;
   localparam int unsigned XLEN = 32;
   localparam int unsigned IMM_WIDTH = 21;
   localparam int unsigned REM_STEPS = 8;
   localparam int unsigned REM_BITS = XLEN / REM_STEPS;

   typedef enum logic [2:0] {
      KIND_ALU_REG = 3'd0,
      KIND_ALU_IMM = 3'd1,
      KIND_LOAD    = 3'd2,
      KIND_STORE   = 3'd3,
      KIND_BRANCH  = 3'd4,
      KIND_JAL     = 3'd5,
      KIND_JALR    = 3'd6,
      KIND_NONE    = 3'd7
   } kind_type;

   localparam logic [3:0] FN_ADD  = 4'd0;
   localparam logic [3:0] FN_SUB  = 4'd1;
   localparam logic [3:0] FN_SLL  = 4'd2;
   localparam logic [3:0] FN_SLT  = 4'd3;
   localparam logic [3:0] FN_SLTU = 4'd4;
   localparam logic [3:0] FN_XOR  = 4'd5;
   localparam logic [3:0] FN_SRL  = 4'd6;
   localparam logic [3:0] FN_SRA  = 4'd7;
   localparam logic [3:0] FN_OR   = 4'd8;
   localparam logic [3:0] FN_AND  = 4'd9;
   localparam logic [3:0] FN_REM  = 4'd10;

   localparam logic [3:0] BR_EQ  = 4'd0;
   localparam logic [3:0] BR_NE  = 4'd1;
   localparam logic [3:0] BR_LT  = 4'd2;
   localparam logic [3:0] BR_GE  = 4'd3;
   localparam logic [3:0] BR_LTU = 4'd4;
   localparam logic [3:0] BR_GEU = 4'd5;

   typedef struct packed {
      logic [2:0]      kind;
      logic [3:0]      func;
      logic [XLEN-1:0] operand_a;
      logic [XLEN-1:0] operand_b;
      logic [IMM_WIDTH-1:0] immediate;
      logic [XLEN-1:0] pc_in;
   } req_type;

   typedef struct packed {
      logic [XLEN-1:0] result;
      logic [XLEN-1:0] store_data;
      logic [XLEN-1:0] next_pc;
      logic            taken;
   } rsp_type;
endpackage
`default_nettype wire

// File: hdl/rv32eb_if.sv
// valid/ready channel interface
`default_nettype none
interface rv32eb_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/rv32_execute_and_branch_unit.sv
// execute and branch unit: pipelined alu, branch resolve and remainder
//
//  channel  | dir | payload
//  req      | in  | kind func operand_a operand_b immediate pc_in
//  rsp      | out | result store_data next_pc taken
//
// one item per cycle while the output is not stalled; the remainder restoring
// divider, 4 restoring steps per stage over 8 stages, sets the depth.
// a stall at the output holds the output stage and the full stages right behind it,
// but an empty stage or bubble lets the items before it advance.
// reset clears the valid bits only.
`default_nettype none
module rv32_execute_and_branch_unit (
   input  wire logic clock,
   input  wire logic reset,
   rv32eb_if.sink    req,
   rv32eb_if.source  rsp
);
   import rv32eb_pkg::*;

   localparam int NST = REM_STEPS + 2;

   typedef struct packed {
      logic [XLEN-1:0] result;
      logic [XLEN-1:0] store_data;
      logic [XLEN-1:0] next_pc;
      logic            taken;
      logic            is_rem;
      logic            neg;
      logic [XLEN-1:0] rem;
      logic [XLEN-1:0] quo;
      logic [XLEN-1:0] div;
   } st_type;

   logic [NST-1:0] vld_ff, vld_in;
   st_type         st_ff [NST];
   st_type         st_in [NST];
   logic [NST-1:0] adv;

   // stage advances when its slot is empty or moves on
   always_comb begin
      adv[NST-1] = !vld_ff[NST-1] || rsp.ready;
      for (int i = NST-2; i >= 0; i--) adv[i] = !vld_ff[i] || adv[i+1];
   end
   assign req.ready = adv[0];

   // stage 0: decode, simple alu, branch, remainder setup
   logic [XLEN-1:0] a, b, imm, opb, seq, alu_r;
   logic [4:0]      sh;
   logic            lts, ltu, brh;
   req_type         r;
   st_type          s0;
   always_comb begin
      r   = req.payload;
      a   = r.operand_a;
      b   = r.operand_b;
      imm = {{(XLEN-IMM_WIDTH){r.immediate[IMM_WIDTH-1]}}, r.immediate};
      opb = (kind_type'(r.kind) == KIND_ALU_IMM) ? imm : b;
      sh  = opb[4:0];
      seq = r.pc_in + 32'd4;
      lts = $signed(a) < $signed(opb);
      ltu = a < opb;
      case (r.func)
         FN_ADD:  alu_r = a + opb;
         FN_SUB:  alu_r = a - opb;
         FN_SLL:  alu_r = a << sh;
         FN_SLT:  alu_r = {31'd0, lts};
         FN_SLTU: alu_r = {31'd0, ltu};
         FN_XOR:  alu_r = a ^ opb;
         FN_SRL:  alu_r = a >> sh;
         FN_SRA:  alu_r = XLEN'($signed(a) >>> sh);
         FN_OR:   alu_r = a | opb;
         FN_AND:  alu_r = a & opb;
         default: alu_r = '0;
      endcase
      case (r.func)
         BR_EQ:   brh = a == b;
         BR_NE:   brh = a != b;
         BR_LT:   brh = $signed(a) < $signed(b);
         BR_GE:   brh = !($signed(a) < $signed(b));
         BR_LTU:  brh = a < b;
         BR_GEU:  brh = !(a < b);
         default: brh = 1'b0;
      endcase
      s0 = '0;
      s0.next_pc = seq;
      case (kind_type'(r.kind))
         KIND_ALU_REG, KIND_ALU_IMM: begin
            s0.result = alu_r;
            s0.is_rem = (r.func == FN_REM);
         end
         KIND_LOAD: s0.result = a + imm;
         KIND_STORE: begin
            s0.result = a + imm;
            s0.store_data = b;
         end
         KIND_BRANCH: begin
            if (brh) begin
               s0.next_pc = r.pc_in + imm;
               s0.taken = 1'b1;
            end
         end
         KIND_JAL: begin
            s0.result = seq;
            s0.next_pc = r.pc_in + imm;
            s0.taken = 1'b1;
         end
         KIND_JALR: begin
            s0.result = seq;
            s0.next_pc = (a + imm) & ~32'd1;
            s0.taken = 1'b1;
         end
         default: ;
      endcase
      // magnitudes for the divider; quotient reg holds dividend bits
      s0.neg = a[XLEN-1];
      s0.quo = a[XLEN-1] ? 32'd0 - a : a;
      s0.div = opb[XLEN-1] ? 32'd0 - opb : opb;
      s0.rem = '0;
      // remainder by zero returns the dividend
      if (s0.is_rem && opb == '0) begin
         s0.is_rem = 1'b0;
         s0.result = a;
      end
   end

   // divider stages: REM_BITS restoring steps each
   always_comb begin
      st_in[0] = s0;
      for (int k = 1; k <= REM_STEPS; k++) begin
         st_in[k] = st_ff[k-1];
         for (int j = 0; j < REM_BITS; j++) begin
            logic [XLEN:0] t;
            t = {st_in[k].rem, st_in[k].quo[XLEN-1]} - {1'b0, st_in[k].div};
            if (!t[XLEN]) st_in[k].rem = t[XLEN-1:0];
            else st_in[k].rem = {st_in[k].rem[XLEN-2:0], st_in[k].quo[XLEN-1]};
            st_in[k].quo = {st_in[k].quo[XLEN-2:0], 1'b0};
         end
      end
      // final: sign fix; overflow case yields zero naturally
      st_in[NST-1] = st_ff[NST-2];
      if (st_ff[NST-2].is_rem)
         st_in[NST-1].result = st_ff[NST-2].neg ? 32'd0 - st_ff[NST-2].rem
                                                : st_ff[NST-2].rem;
   end

   always_comb begin
      vld_in[0] = req.valid;
      for (int i = 1; i < NST; i++) vld_in[i] = vld_ff[i-1];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NST; i++) begin
         if (adv[i]) st_ff[i] <= st_in[i];
      end
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (adv[i]) vld_ff[i] <= vld_in[i];
         end
      end
   end

   assign rsp.valid              = vld_ff[NST-1];
   assign rsp.payload.result     = st_ff[NST-1].result;
   assign rsp.payload.store_data = st_ff[NST-1].store_data;
   assign rsp.payload.next_pc    = st_ff[NST-1].next_pc;
   assign rsp.payload.taken      = st_ff[NST-1].taken;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("output changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("pipe stalled with empty output");
   a_store: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.store_data != '0 |-> !rsp.payload.taken)
      else $error("store item marked taken");
endmodule
`default_nettype wire

// File: bench/rv32_execute_and_branch_unit_checker.sv
// checker for the execute and branch unit: predicts each result and compares it
`timescale 1ns / 1ps
module rv32_execute_and_branch_unit_checker (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_ready,
   input  rv32eb_pkg::req_type req_item,
   input  wire logic          rsp_valid,
   input  wire logic          rsp_ready,
   input  rv32eb_pkg::rsp_type rsp_item,
   output int                 errors,
   output int                 pending,
   output int                 results_seen,
   output int                 taken_seen
);
   import rv32eb_pkg::*;

   rsp_type exec_queue[$];

   function automatic logic signed_less(logic [31:0] a, logic [31:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic logic [31:0] alu_value(logic [3:0] f, logic [31:0] a, logic [31:0] b);
      logic [4:0] sh;
      logic [31:0] ma, mb, r;
      sh = b[4:0];
      case (f)
         FN_ADD:  return a + b;
         FN_SUB:  return a - b;
         FN_SLL:  return a << sh;
         FN_SLT:  return {31'd0, signed_less(a, b)};
         FN_SLTU: return {31'd0, a < b};
         FN_XOR:  return a ^ b;
         FN_SRL:  return a >> sh;
         FN_SRA:  return $signed(a) >>> sh;
         FN_OR:   return a | b;
         FN_AND:  return a & b;
         FN_REM: begin
            if (b == 32'd0) return a;
            if (a == 32'h8000_0000 && b == 32'hffff_ffff) return '0;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            r = ma % mb;
            return a[31] ? -r : r;
         end
         default: return '0;
      endcase
   endfunction

   function automatic logic branch_holds(logic [3:0] f, logic [31:0] a, logic [31:0] b);
      case (f)
         BR_EQ:  return a == b;
         BR_NE:  return a != b;
         BR_LT:  return signed_less(a, b);
         BR_GE:  return !signed_less(a, b);
         BR_LTU: return a < b;
         BR_GEU: return a >= b;
         default: return 1'b0;
      endcase
   endfunction

   function automatic rsp_type execute(req_type q);
      rsp_type o;
      logic [31:0] imm, seq;
      imm = {{11{q.immediate[20]}}, q.immediate};
      seq = q.pc_in + 32'd4;
      o = '0;
      o.next_pc = seq;
      case (kind_type'(q.kind))
         KIND_ALU_REG: o.result = alu_value(q.func, q.operand_a, q.operand_b);
         KIND_ALU_IMM: o.result = alu_value(q.func, q.operand_a, imm);
         KIND_LOAD:    o.result = q.operand_a + imm;
         KIND_STORE: begin
            o.result = q.operand_a + imm;
            o.store_data = q.operand_b;
         end
         KIND_BRANCH: begin
            if (branch_holds(q.func, q.operand_a, q.operand_b)) begin
               o.next_pc = q.pc_in + imm;
               o.taken = 1'b1;
            end
         end
         KIND_JAL: begin
            o.result = seq;
            o.next_pc = q.pc_in + imm;
            o.taken = 1'b1;
         end
         KIND_JALR: begin
            o.result = seq;
            o.next_pc = (q.operand_a + imm) & ~32'd1;
            o.taken = 1'b1;
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         errors <= 0;
         results_seen <= 0;
         taken_seen <= 0;
         exec_queue.delete();
      end else begin
         if (req_valid && req_ready)
            exec_queue.insert(exec_queue.size(), execute(req_item));
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (rsp_item.taken) taken_seen <= taken_seen + 1;
            if (exec_queue.size() == 0) begin
               if (errors < 10) $display("unexpected item: %h", rsp_item);
               errors <= errors + 1;
            end else begin
               want = exec_queue.pop_front();
               if (want !== rsp_item) begin
                  if (errors < 10)
                     $display("mismatch: result %h/%h store %h/%h npc %h/%h taken %b/%b",
                        want.result, rsp_item.result, want.store_data,
                        rsp_item.store_data, want.next_pc, rsp_item.next_pc,
                        want.taken, rsp_item.taken);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

   assign pending = exec_queue.size();
endmodule

// File: bench/rv32_execute_and_branch_unit_test.sv
// testbench top: instruction stimulus, result stalls and verdict
`timescale 1ns / 1ps
module rv32_execute_and_branch_unit_test;
   import rv32eb_pkg::*;

   localparam int RANDOM_ITEMS = 630;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int errors, pending, results_seen, taken_seen;
   int sent = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit hold_long = 1'b0;

   rv32eb_if #(.payload_type(req_type)) req_ch ();
   rv32eb_if #(.payload_type(rsp_type)) rsp_ch ();

   rv32_execute_and_branch_unit u_top (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   rv32_execute_and_branch_unit_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_item(req_ch.payload),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_item(rsp_ch.payload),
      .errors(errors), .pending(pending), .results_seen(results_seen),
      .taken_seen(taken_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'd0;
         4: return $urandom_range(0, 40) - 20;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_instr();
      req_type q;
      q.kind = 3'($urandom_range(0, 7));
      q.func = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 10));
      if (q.kind == KIND_BRANCH && $urandom_range(0, 3) != 0)
         q.func = 4'($urandom_range(0, 5));
      q.operand_a = pick_word();
      q.operand_b = ($urandom_range(0, 3) == 0) ? q.operand_a : pick_word();
      q.immediate = 21'(pick_word());
      q.pc_in = ($urandom_range(0, 7) == 0) ? 32'hffff_fffc - 4 * $urandom_range(0, 3)
                                            : $urandom;
      return q;
   endfunction

   // offers one item, with a random gap first unless in the quiet tail
   task automatic send(req_type q);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= q;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   task automatic directed(logic [2:0] k, logic [3:0] f, logic [31:0] a, logic [31:0] b,
                           logic [20:0] imm, logic [31:0] pc);
      send('{k, f, a, b, imm, pc});
   endtask

   initial begin
      req_type q;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed(KIND_ALU_REG, FN_REM, 32'h8000_0000, 32'hffff_ffff, 21'd0, 32'd0);
      directed(KIND_ALU_REG, FN_REM, 32'h1234_5678, 32'd0, 21'd0, 32'd4);
      directed(KIND_ALU_REG, FN_REM, 32'hffff_fff9, 32'd3, 21'd0, 32'd8);
      directed(KIND_ALU_REG, FN_SLL, 32'h0000_0001, 32'h0000_003f, 21'd0, 32'd12);
      directed(KIND_ALU_REG, FN_SRA, 32'h8000_0000, 32'hffff_ffe1, 21'd0, 32'd16);
      directed(KIND_ALU_REG, FN_SRL, 32'h8000_0000, 32'd31, 21'd0, 32'd20);
      directed(KIND_ALU_REG, FN_SLT, 32'h8000_0000, 32'h7fff_ffff, 21'd0, 32'd24);
      directed(KIND_ALU_REG, FN_SLTU, 32'h8000_0000, 32'h7fff_ffff, 21'd0, 32'd28);
      directed(KIND_ALU_IMM, FN_SLTU, 32'h7fff_ffff, 32'd0, 21'h1f_ffff, 32'd32);
      directed(KIND_ALU_IMM, FN_SUB, 32'd0, 32'd0, 21'h10_0000, 32'd36);
      directed(KIND_ALU_IMM, FN_REM, 32'd100, 32'd0, 21'h0f_ffff, 32'd40);
      directed(KIND_ALU_REG, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 21'd0, 32'd44);
      directed(KIND_LOAD, FN_ADD, 32'hffff_fffc, 32'd0, 21'd8, 32'd48);
      directed(KIND_STORE, FN_ADD, 32'd0, 32'hdead_beef, 21'h10_0000, 32'd52);
      for (int f = 0; f < 6; f++)
         directed(KIND_BRANCH, 4'(f), 32'hffff_ffff, 32'd1, 21'h1f_fff8, 32'd56);
      directed(KIND_BRANCH, 4'd9, 32'd5, 32'd5, 21'd16, 32'd60);
      directed(KIND_JAL, FN_ADD, 32'd0, 32'd0, 21'h0f_fffe, 32'hffff_fffc);
      directed(KIND_JALR, FN_ADD, 32'h0000_1001, 32'd0, 21'd2, 32'd64);
      directed(KIND_NONE, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 21'h1f_ffff, 32'hffff_fffc);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - 60) quiet = 1'b1;
         if (i == 200) hold_long = 1'b1;
         q = random_instr();
         send(q);
      end
      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d instructions sent, %0d results checked, %0d taken branches or jumps",
               sent, results_seen, taken_seen);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // result side: random stall bursts plus one long hold while items keep coming
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_long) begin
            hold_long = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (40) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(1, 4);
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress after %0d cycles", WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end
endmodule
